/* hdl/gwm_pkg.sv */
`default_nettype none

package gwm_pkg;

  localparam int WORD_LEN      = 4;
  localparam int TAIL          = WORD_LEN - 1;
  localparam int CHAR_W        = 8;
  localparam int WORD_W        = 32;
  localparam int ENTRY_W       = CHAR_W * TAIL;
  localparam int HITS_W        = 4;
  localparam int TOTAL_W       = 24;
  localparam int DEF_MAX_WIDTH = 256;

  localparam logic [WORD_W-1:0] TARGET_RESET = 32'h584D4153;

  // register index, taken from paddr[2]
  localparam logic REG_TARGET = 1'b0;

  // one line of the search, far end first, current cell last
  typedef logic [WORD_LEN-1:0][CHAR_W-1:0] line_t;

  typedef struct packed {
    logic first_col;
    logic wr_ok;
    logic horiz_ok;
    logic vert_ok;
    logic diag_ok;
    logic anti_ok;
    logic err;
    logic done;
  } item_t;

  // character k of the word, first character in the top byte
  function automatic logic [CHAR_W-1:0] word_char(input logic [WORD_W-1:0] w,
                                                  input int k);
    logic [2*WORD_W-1:0] ext;
    ext = {{WORD_W{1'b0}}, w} >> (CHAR_W * (WORD_LEN - 1 - k));
    return ext[CHAR_W-1:0];
  endfunction

  // forward and reversed match of one line
  function automatic logic [1:0] line_hits(input line_t seq,
                                           input logic [WORD_W-1:0] w);
    logic fwd;
    logic rev;
    fwd = 1'b1;
    rev = 1'b1;
    for (int k = 0; k < WORD_LEN; k++) begin
      if (seq[k] != word_char(w, k)) fwd = 1'b0;
      if (seq[k] != word_char(w, WORD_LEN - 1 - k)) rev = 1'b0;
    end
    return {1'b0, fwd} + {1'b0, rev};
  endfunction

endpackage

`default_nettype wire

/* hdl/grid_word_match_counter.sv */
`default_nettype none

// channel   dir  beat contents                              handshake
// in_       in   ch, last_in_row, last_in_grid              in_valid / in_ready
// out_      out  hits_here, total_hits, grid_done,          out_valid / out_ready
//                shape_error
// cfg (APB) in   target_word at byte 0 (paddr[2] = 0)       psel, penable, pready = 1
//
// Sustains one beat per cycle unless out_ stalls; a taken beat is registered in the window
// stage with the row store read of the column three ahead, then in the output register.
// A write-back to the same store entry in flight is forwarded; row starts use a small copy
// of the first store entries. No clearing pass: the store is undefined until written.
// rst_n clears counters, flags and the running total; the target resets to "XMAS".
// A stalled output holds its beat; one more input beat is still taken behind it.

module grid_word_match_counter #(
  parameter int MAX_WIDTH = gwm_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,

  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [gwm_pkg::CHAR_W-1:0]         in_ch,
  input  wire logic                               in_last_in_row,
  input  wire logic                               in_last_in_grid,

  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic      [gwm_pkg::HITS_W-1:0]         out_hits_here,
  output logic      [gwm_pkg::TOTAL_W-1:0]        out_total_hits,
  output logic                                    out_grid_done,
  output logic                                    out_shape_error,

  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [2:0]                         paddr,
  input  wire logic [gwm_pkg::WORD_W-1:0]         pwdata,
  output logic      [gwm_pkg::WORD_W-1:0]         prdata,
  output logic                                    pready
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int TW = gwm_pkg::TOTAL_W;

  logic [gwm_pkg::WORD_W-1:0] target_r;

  logic                       load;
  logic                       adv;
  logic                       c_en;
  logic [CW-1:0]              col;
  gwm_pkg::item_t             info;
  logic                       b_valid;
  logic [gwm_pkg::HITS_W-1:0] b_hits;
  logic                       b_done;
  logic                       b_err;

  logic [TW:0]                total_sum;
  logic [TW-1:0]              total_sat;
  logic [TW-1:0]              total_r;

  logic                       out_valid_r;
  logic [gwm_pkg::HITS_W-1:0] out_hits_r;
  logic [TW-1:0]              out_total_r;
  logic                       out_done_r;
  logic                       out_err_r;

  // config
  assign pready = 1'b1;
  assign prdata = (paddr[2] == gwm_pkg::REG_TARGET) ? target_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= gwm_pkg::TARGET_RESET;
    end else if (psel && penable && pwrite && paddr[2] == gwm_pkg::REG_TARGET) begin
      target_r <= pwdata;
    end
  end

  // pipeline control
  assign c_en     = ~out_valid_r | out_ready;
  assign adv      = b_valid & c_en;
  assign in_ready = ~b_valid | c_en;
  assign load     = in_valid & in_ready;

  gwm_shape #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_shape (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (load),
    .last_in_row  (in_last_in_row),
    .last_in_grid (in_last_in_grid),
    .col          (col),
    .info         (info)
  );

  gwm_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (load),
    .adv     (adv),
    .in_ch   (in_ch),
    .col     (col),
    .info    (info),
    .target  (target_r),
    .b_valid (b_valid),
    .b_hits  (b_hits),
    .b_done  (b_done),
    .b_err   (b_err)
  );

  assign total_sum = {1'b0, total_r} + (TW+1)'(b_hits);
  assign total_sat = total_sum[TW] ? {TW{1'b1}} : total_sum[TW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
      total_r     <= b_done ? '0 : total_sat;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hits_r  <= b_hits;
      out_total_r <= total_sat;
      out_done_r  <= b_done;
      out_err_r   <= b_err;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hits_here   = out_hits_r;
  assign out_total_hits  = out_total_r;
  assign out_grid_done   = out_done_r;
  assign out_shape_error = out_err_r;

endmodule

`default_nettype wire

/* hdl/gwm_ram.sv */
`default_nettype none

module gwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/gwm_shape.sv */
`default_nettype none

module gwm_shape #(
  parameter int MAX_WIDTH = gwm_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             load,
  input  wire logic                             last_in_row,
  input  wire logic                             last_in_grid,
  output logic      [$clog2(MAX_WIDTH+1)-1:0]   col,
  output gwm_pkg::item_t                        info
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_WIDTH + gwm_pkg::WORD_LEN + 1);
  localparam int SW = $clog2(gwm_pkg::TAIL + 1);

  logic [CW-1:0] column_r,    column_nxt;
  logic [SW-1:0] rows_seen_r, rows_seen_nxt;
  logic [RW-1:0] row_width_r, row_width_nxt;
  logic          err_r,       err_nxt;

  logic [RW-1:0] col_w;
  logic [RW-1:0] col_inc;
  logic [RW-1:0] reach;
  logic          in_store;
  logic          rows_ok;
  logic          row_end;
  logic          mismatch;

  always_comb begin
    col_w    = RW'(column_r);
    col_inc  = col_w + RW'(1);
    reach    = col_w + RW'(gwm_pkg::TAIL);
    in_store = col_w < RW'(MAX_WIDTH);
    rows_ok  = rows_seen_r == SW'(gwm_pkg::TAIL);
    row_end  = last_in_row | last_in_grid;
    mismatch = row_end && (row_width_r != '0) && (col_inc != row_width_r);

    info.first_col = column_r == '0;
    info.wr_ok     = in_store;
    info.horiz_ok  = col_w >= RW'(gwm_pkg::TAIL);
    info.vert_ok   = rows_ok & in_store;
    info.diag_ok   = rows_ok & in_store & info.horiz_ok;
    info.anti_ok   = rows_ok & in_store & (reach < row_width_r) & (reach < RW'(MAX_WIDTH));
    info.err       = err_r | ~in_store | mismatch;
    info.done      = last_in_grid;
  end

  assign col = column_r;

  always_comb begin
    column_nxt    = column_r;
    rows_seen_nxt = rows_seen_r;
    row_width_nxt = row_width_r;
    err_nxt       = err_r;
    if (load) begin
      if (last_in_grid) begin
        column_nxt    = '0;
        rows_seen_nxt = '0;
        row_width_nxt = '0;
        err_nxt       = 1'b0;
      end else begin
        err_nxt = info.err;
        if (row_end) begin
          if (row_width_r == '0) row_width_nxt = col_inc;
          if (!rows_ok) rows_seen_nxt = rows_seen_r + SW'(1);
          column_nxt = '0;
        end else if (in_store) begin
          column_nxt = column_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r    <= '0;
      rows_seen_r <= '0;
      row_width_r <= '0;
      err_r       <= 1'b0;
    end else begin
      column_r    <= column_nxt;
      rows_seen_r <= rows_seen_nxt;
      row_width_r <= row_width_nxt;
      err_r       <= err_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/gwm_window.sv */
`default_nettype none

module gwm_window #(
  parameter int MAX_WIDTH = gwm_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                load,
  input  wire logic                                adv,
  input  wire logic [gwm_pkg::CHAR_W-1:0]          in_ch,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]      col,
  input  wire gwm_pkg::item_t                      info,
  input  wire logic [gwm_pkg::WORD_W-1:0]          target,
  output logic                                     b_valid,
  output logic      [gwm_pkg::HITS_W-1:0]          b_hits,
  output logic                                     b_done,
  output logic                                     b_err
);

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_WIDTH + gwm_pkg::WORD_LEN + 1);
  localparam int TAIL = gwm_pkg::TAIL;
  localparam int EW   = gwm_pkg::ENTRY_W;
  localparam int CHW  = gwm_pkg::CHAR_W;
  localparam int HW   = gwm_pkg::HITS_W;

  logic                b_valid_r;
  logic [CHW-1:0]      b_ch_r;
  gwm_pkg::item_t      b_info_r;
  logic [AW-1:0]       b_addr_r;
  logic                b_fwd_r;
  logic [EW-1:0]       b_fwd_data_r;

  // store words of columns c..c+TAIL-1, c-TAIL..c-1, and row chars c-TAIL..c-1
  logic [EW-1:0]       l_r    [TAIL];
  logic [EW-1:0]       p_r    [TAIL];
  logic [CHW-1:0]      h_r    [TAIL];
  // copy of the store entries that open each row
  logic [EW-1:0]       head_r [TAIL];
  logic [EW-1:0]       head_eff [TAIL];

  logic [RW-1:0]       rd_reach;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [EW-1:0]       wr_data;
  logic [EW-1:0]       ram_q;
  logic [EW-1:0]       la;

  gwm_pkg::line_t      horiz, vert, diag, anti;

  assign rd_reach = RW'(col) + RW'(TAIL);
  assign rd_en    = load && (rd_reach < RW'(MAX_WIDTH));
  assign rd_addr  = rd_reach[AW-1:0];
  assign wr_en    = adv && b_info_r.wr_ok;
  assign wr_data  = EW'({l_r[0], b_ch_r});
  assign la       = b_fwd_r ? b_fwd_data_r : ram_q;

  gwm_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_WIDTH)
  ) u_row_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (b_addr_r),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_comb begin
    for (int i = 0; i < TAIL; i++) begin
      head_eff[i] = (wr_en && b_addr_r == AW'(i)) ? wr_data : head_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (load) begin
      b_valid_r <= 1'b1;
    end else if (adv) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b_ch_r       <= in_ch;
      b_info_r     <= info;
      b_addr_r     <= col[AW-1:0];
      b_fwd_r      <= wr_en && rd_en && (b_addr_r == rd_addr);
      b_fwd_data_r <= wr_data;
      for (int i = 0; i < TAIL - 1; i++) begin
        h_r[i] <= h_r[i+1];
        p_r[i] <= p_r[i+1];
      end
      h_r[TAIL-1] <= b_ch_r;
      p_r[TAIL-1] <= l_r[0];
      if (info.first_col) begin
        for (int i = 0; i < TAIL; i++) l_r[i] <= head_eff[i];
      end else begin
        for (int i = 0; i < TAIL - 1; i++) l_r[i] <= l_r[i+1];
        l_r[TAIL-1] <= la;
      end
    end
    for (int i = 0; i < TAIL; i++) begin
      if (wr_en && b_addr_r == AW'(i)) head_r[i] <= wr_data;
    end
  end

  // byte d-1 of a store word is the row d above
  always_comb begin
    for (int k = 0; k < TAIL; k++) begin
      horiz[k] = h_r[k];
      vert[k]  = l_r[0][CHW*(TAIL-k)-1 -: CHW];
      diag[k]  = p_r[k][CHW*(TAIL-k)-1 -: CHW];
      if (k == 0) begin
        anti[k] = la[CHW*TAIL-1 -: CHW];
      end else begin
        anti[k] = l_r[TAIL-k][CHW*(TAIL-k)-1 -: CHW];
      end
    end
    horiz[TAIL] = b_ch_r;
    vert[TAIL]  = b_ch_r;
    diag[TAIL]  = b_ch_r;
    anti[TAIL]  = b_ch_r;
  end

  always_comb begin
    b_hits = '0;
    if (b_info_r.horiz_ok) b_hits = b_hits + HW'(gwm_pkg::line_hits(horiz, target));
    if (b_info_r.vert_ok)  b_hits = b_hits + HW'(gwm_pkg::line_hits(vert, target));
    if (b_info_r.diag_ok)  b_hits = b_hits + HW'(gwm_pkg::line_hits(diag, target));
    if (b_info_r.anti_ok)  b_hits = b_hits + HW'(gwm_pkg::line_hits(anti, target));
  end

  assign b_valid = b_valid_r;
  assign b_done  = b_info_r.done;
  assign b_err   = b_info_r.err;

endmodule

`default_nettype wire
